/* hw/rtl/hbbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbbc_pkg
// Shared types and constants of the hashed block buffer cache: geometry,
// command and status codes, transfer payloads, slot entry layout, and the
// table used for the digit-by-digit bucket reduction.
// ----------------------------------------------------------------------------
package hbbc_pkg;

   // Cache geometry
   localparam int NUM_BUCKETS      = 5;
   localparam int SLOTS_PER_BUCKET = 32;
   localparam int TOTAL_SLOTS      = NUM_BUCKETS * SLOTS_PER_BUCKET;

   localparam int ADDR_W   = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
   localparam int OFF_W    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int BUCKET_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

   // Bucket reduction works on one nibble of the block number per step
   localparam int NIBBLE_W       = 4;
   localparam int MOD_TABLE_SIZE = 1 << (BUCKET_W + NIBBLE_W);

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   // Command codes
   localparam logic [1:0] CMD_GET     = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_PIN     = 2'd2;
   localparam logic [1:0] CMD_UNPIN   = 2'd3;

   // Status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NO_BUF = 2'd1;
   localparam logic [1:0] STATUS_LIMIT  = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  device;
      logic [31:0] block_number;
      logic [7:0]  slot_in;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [7:0] slot_out;
      logic       was_hit;
      logic       needs_read;
      logic [1:0] status;
   } rsp_type;

   // One slot as held in the tag RAM
   typedef struct packed {
      logic [7:0]  device;
      logic [31:0] block;
      logic [7:0]  count;
      logic        contents_valid;
      logic [31:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // (remainder * 16 + nibble) mod NUM_BUCKETS, indexed by {remainder, nibble}
   typedef logic [BUCKET_W-1:0] mod_table_type [MOD_TABLE_SIZE];

   function automatic mod_table_type build_mod_table();
      mod_table_type t;
      for (int i = 0; i < MOD_TABLE_SIZE; i++) begin
         t[i] = BUCKET_W'(i % NUM_BUCKETS);
      end
      return t;
   endfunction

   localparam mod_table_type MOD_TABLE = build_mod_table();

endpackage

/* hw/rtl/hbbc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

/* hw/rtl/hashed_block_buffer_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache
// Tag and reference manager for a hashed disk block buffer cache. A small
// sequencer reduces the block number to a bucket one nibble per cycle, then
// scans the bucket's slots through one tag RAM read port and one comparator.
// ----------------------------------------------------------------------------
// Get: bucket reduction in ST_MOD, then one slot per cycle through the RAM read
//   port in ST_SCAN; a hit at offset k ends the scan there, a miss scans all
//   SLOTS_PER_BUCKET slots. busy is high until the result cycle.
// Release, pin, unpin: one RAM read and, unless the count is at its limit, one
//   write in ST_UPDATE; an out-of-range slot answers on the next cycle.
// The receiver cannot stall: each result shows for one cycle only.
// Synchronous reset clears the sequencer and the per-slot valid bits; a slot
// whose valid bit is clear reads as all zero.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache
   import hbbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MOD    = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_FINISH = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;

   logic [2:0]          state_ff, state_in;
   req_type             req_ff, req_in;
   logic [2:0]          nib_cnt_ff, nib_cnt_in;
   logic [BUCKET_W-1:0] bucket_ff, bucket_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [OFF_W:0]      issue_ff, issue_in;
   logic                cmp_pend_ff, cmp_pend_in;
   logic [OFF_W-1:0]    cmp_off_ff, cmp_off_in;
   logic                have_ff, have_in;
   logic                hit_ff, hit_in;
   logic [ADDR_W-1:0]   sel_idx_ff, sel_idx_in;
   logic [7:0]          sel_cnt_ff, sel_cnt_in;
   logic                sel_cv_ff, sel_cv_in;
   logic [31:0]         sel_stamp_ff, sel_stamp_in;
   logic                vld_ff [TOTAL_SLOTS];
   logic                vld_rd_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata;
   entry_type           wr_ent;
   entry_type           rd_ent;
   logic [3:0]          nibble;
   logic [ADDR_W-1:0]   cmp_addr;
   logic                tag_match;
   logic                eligible;

   // tag RAM, one entry per slot
   hbbc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TOTAL_SLOTS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (wr_ent),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // never-written slots read as zero
   assign rd_ent = vld_rd_ff ? entry_type'(ram_rdata) : '0;

   // nibble of the block number, most significant first
   assign nibble   = req_ff.block_number[{~nib_cnt_ff, 2'b00} +: NIBBLE_W];

   // slot compare for the scan
   assign cmp_addr  = base_ff + ADDR_W'(cmp_off_ff);
   assign tag_match = (rd_ent.device == req_ff.device) &&
                      (rd_ent.block == req_ff.block_number);
   assign eligible  = (rd_ent.count == 8'd0) &&
                      (!have_ff || (rd_ent.stamp < sel_stamp_ff));

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      nib_cnt_in    = nib_cnt_ff;
      bucket_in     = bucket_ff;
      base_in       = base_ff;
      issue_in      = issue_ff;
      cmp_pend_in   = cmp_pend_ff;
      cmp_off_in    = cmp_off_ff;
      have_in       = have_ff;
      hit_in        = hit_ff;
      sel_idx_in    = sel_idx_ff;
      sel_cnt_in    = sel_cnt_ff;
      sel_cv_in     = sel_cv_ff;
      sel_stamp_in  = sel_stamp_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = sel_idx_ff;
      ram_raddr     = base_ff + ADDR_W'(issue_ff[OFF_W-1:0]);
      wr_ent        = rd_ent;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               if (req_item.command == CMD_GET) begin
                  nib_cnt_in = 3'd0;
                  bucket_in  = '0;
                  state_in   = ST_MOD;
               end else if (int'(req_item.slot_in) >= TOTAL_SLOTS) begin
                  // out-of-range slot: ignored
                  rsp_in        = '{slot_out: req_item.slot_in, was_hit: 1'b0,
                                    needs_read: 1'b0, status: STATUS_OK};
                  rsp_strobe_in = 1'b1;
               end else begin
                  ram_raddr = ADDR_W'(req_item.slot_in);
                  state_in  = ST_UPDATE;
               end
            end
         end

         ST_MOD: begin
            bucket_in  = MOD_TABLE[{bucket_ff, nibble}];
            nib_cnt_in = nib_cnt_ff + 3'd1;
            if (nib_cnt_ff == 3'd7) begin
               base_in     = ADDR_W'(bucket_in) * ADDR_W'(SLOTS_PER_BUCKET);
               issue_in    = '0;
               cmp_pend_in = 1'b0;
               have_in     = 1'b0;
               hit_in      = 1'b0;
               state_in    = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // read issue, one slot per cycle
            if (issue_ff < (OFF_W+1)'(SLOTS_PER_BUCKET)) begin
               issue_in    = issue_ff + 1'b1;
               cmp_pend_in = 1'b1;
               cmp_off_in  = issue_ff[OFF_W-1:0];
            end else begin
               cmp_pend_in = 1'b0;
            end
            // compare on the slot read last cycle
            if (cmp_pend_ff) begin
               if (tag_match) begin
                  hit_in       = 1'b1;
                  sel_idx_in   = cmp_addr;
                  sel_cnt_in   = rd_ent.count;
                  sel_cv_in    = rd_ent.contents_valid;
                  sel_stamp_in = rd_ent.stamp;
                  state_in     = ST_FINISH;
               end else begin
                  if (eligible) begin
                     have_in      = 1'b1;
                     sel_idx_in   = cmp_addr;
                     sel_stamp_in = rd_ent.stamp;
                  end
                  if (cmp_off_ff == OFF_W'(SLOTS_PER_BUCKET - 1)) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end

         ST_FINISH: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            wr_ent.device         = req_ff.device;
            wr_ent.block          = req_ff.block_number;
            wr_ent.contents_valid = 1'b1;
            wr_ent.stamp          = sel_stamp_ff;
            priority if (hit_ff) begin
               ram_we       = 1'b1;
               wr_ent.count = (sel_cnt_ff == COUNT_MAX) ? sel_cnt_ff : sel_cnt_ff + 8'd1;
               rsp_in       = '{slot_out: 8'(sel_idx_ff), was_hit: 1'b1,
                                needs_read: !sel_cv_ff,
                                status: (sel_cnt_ff == COUNT_MAX) ? STATUS_LIMIT
                                                                  : STATUS_OK};
            end else if (have_ff) begin
               ram_we       = 1'b1;
               wr_ent.count = 8'd1;
               rsp_in       = '{slot_out: 8'(sel_idx_ff), was_hit: 1'b0,
                                needs_read: 1'b1, status: STATUS_OK};
            end else begin
               rsp_in = '{slot_out: req_ff.slot_in, was_hit: 1'b0,
                          needs_read: 1'b0, status: STATUS_NO_BUF};
            end
         end

         ST_UPDATE: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            ram_waddr     = ADDR_W'(req_ff.slot_in);
            rsp_in        = '{slot_out: req_ff.slot_in, was_hit: 1'b0,
                              needs_read: 1'b0, status: STATUS_OK};
            if (req_ff.command == CMD_PIN) begin
               if (rd_ent.count == COUNT_MAX) begin
                  rsp_in.status = STATUS_LIMIT;
               end else begin
                  ram_we       = 1'b1;
                  wr_ent.count = rd_ent.count + 8'd1;
               end
            end else begin
               // release or unpin
               if (rd_ent.count == 8'd0) begin
                  rsp_in.status = STATUS_LIMIT;
               end else begin
                  ram_we       = 1'b1;
                  wr_ent.count = rd_ent.count - 8'd1;
                  if ((req_ff.command == CMD_RELEASE) && (rd_ent.count == 8'd1)) begin
                     wr_ent.stamp = req_ff.now;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < TOTAL_SLOTS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (ram_we) begin
            vld_ff[ram_waddr] <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      nib_cnt_ff   <= nib_cnt_in;
      bucket_ff    <= bucket_in;
      base_ff      <= base_in;
      issue_ff     <= issue_in;
      cmp_pend_ff  <= cmp_pend_in;
      cmp_off_ff   <= cmp_off_in;
      have_ff      <= have_in;
      hit_ff       <= hit_in;
      sel_idx_ff   <= sel_idx_in;
      sel_cnt_ff   <= sel_cnt_in;
      sel_cv_ff    <= sel_cv_in;
      sel_stamp_ff <= sel_stamp_in;
      rsp_ff       <= rsp_in;
      vld_rd_ff    <= vld_ff[ram_raddr];
   end

endmodule
